### rtl/core/assert_macros.svh
// assertion macros for the rtl modules
// expects clk and rst_n in scope where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off while in reset
`define SWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal must stay true every clock outside reset
`define SWM_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

### rtl/core/swm_pkg.sv
// types and constants for the sliding window maximum filter
// no dependencies
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 7;
  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = CFG_W'(3);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]           cfg_len_t;

endpackage

### rtl/core/sliding_window_max_filter_top.sv
// sliding window maximum filter, one cell per possible window length
// out_tvalid rises the cycle after a request that completes a window; one sample per cycle
// the output register frees in the same cycle it is taken, so input stalls only on output stall
// a result is the tap of the cell chain selected by the window length
// reset clears fill count, output valid and window_length (to 3); cells hold no reset
module sliding_window_max_filter_top #(
  parameter int MAX_WINDOW = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  input  logic [0:0]  in_tuser,   // [0] stream_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] window_maximum
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);
  import swm_pkg::*;

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_WINDOW);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WINDOW);

  cfg_len_t         window_length_r;
  logic [LEN_W-1:0] fill_r;
  logic [LEN_W-1:0] fill_nxt;
  logic [LEN_W-1:0] fill_base;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] eff_ext;
  logic [LEN_W-1:0] eff_len;
  logic [IDX_W-1:0] tap;
  logic             in_acc;
  logic             hit;
  logic             out_valid_r;
  sample_t          out_data_r;
  sample_t          sample;
  sample_t          tap_max;

  assign sample = sample_t'(in_tdata);

  // zero acts as one, oversize clamps to the chain depth
  always_comb begin
    len_ext = CMP_W'(window_length_r);
    if (len_ext == '0) begin
      eff_ext = CMP_W'(1);
    end else if (len_ext > MAX_CMP) begin
      eff_ext = MAX_CMP;
    end else begin
      eff_ext = len_ext;
    end
  end

  assign eff_len = eff_ext[LEN_W-1:0];
  assign tap     = IDX_W'(eff_len - LEN_W'(1));

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    fill_base = in_tuser[0] ? '0 : fill_r;
    fill_nxt  = (fill_base < MAX_LEN) ? fill_base + LEN_W'(1) : fill_base;
  end

  assign hit = (fill_nxt >= eff_len);

  swm_chain #(
    .DEPTH (MAX_WINDOW),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk      (clk),
    .shift_en (in_acc),
    .sample   (sample),
    .tap      (tap),
    .tap_max  (tap_max)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WINDOW_LENGTH_RST;
      fill_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_length_r <= cfg_wr_data;
      end
      if (in_acc) begin
        fill_r      <= fill_nxt;
        out_valid_r <= hit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && hit) begin
      out_data_r <= tap_max;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `include "assert_macros.svh"

  `SWM_ASSERT_ALWAYS(a_fill_bound, fill_r <= MAX_LEN, "fill count above window depth")
  `SWM_ASSERT(a_start_no_result, in_acc && in_tuser[0] && eff_len != LEN_W'(1) |=> !out_valid_r, "result on first sample of a stream")
  `SWM_ASSERT(a_fill_saturates, in_acc && !in_tuser[0] && fill_r == MAX_LEN |=> fill_r == MAX_LEN, "fill count left saturation")

endmodule

### rtl/core/swm_cell.sv
// one cell of the max chain: holds the max of the last k+1 samples
// depends on swm_pkg
module swm_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  swm_pkg::sample_t sample_i,
  input  swm_pkg::sample_t prev_i,
  output swm_pkg::sample_t max_nxt_o,
  output swm_pkg::sample_t max_o
);
  import swm_pkg::*;

  sample_t max_r;
  sample_t max_nxt;

  // new window of k+1 = new sample plus the neighbor's window of k
  assign max_nxt = (prev_i > sample_i) ? prev_i : sample_i;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      max_r <= max_nxt;
    end
  end

  assign max_nxt_o = max_nxt;
  assign max_o     = max_r;

endmodule

### rtl/core/swm_chain.sv
// row of swm_cell instances, one per window length, with the tap select
// depends on swm_pkg and swm_cell
module swm_chain #(
  parameter int DEPTH = 64,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             shift_en,
  input  swm_pkg::sample_t sample,
  input  logic [IDX_W-1:0] tap,
  output swm_pkg::sample_t tap_max
);
  import swm_pkg::*;

  sample_t cell_q [DEPTH];
  sample_t cell_n [DEPTH];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      sample_t prev;
      // first cell compares the sample with itself
      if (g == 0) begin : g_head
        assign prev = sample;
      end else begin : g_body
        assign prev = cell_q[g-1];
      end
      swm_cell u_cell (
        .clk       (clk),
        .shift_en  (shift_en),
        .sample_i  (sample),
        .prev_i    (prev),
        .max_nxt_o (cell_n[g]),
        .max_o     (cell_q[g])
      );
    end
  endgenerate

  // tap picks the updated max over the selected window length
  assign tap_max = cell_n[tap];

endmodule

### dv/tb.sv
// testbench for sliding_window_max_filter_top: directed and random sample streams
// run against a window-maximum predictor in a small scoreboard class
// depends on swm_pkg and the rtl top level only
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swm_pkg::*;

  localparam int WINDOW_DEPTH   = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int IDLE_PCT       = 16;

  localparam sample_t SAMPLE_MIN = sample_t'(32'h8000_0000);
  localparam sample_t SAMPLE_MAX = sample_t'(32'h7fff_ffff);

  class window_max_scoreboard;
    sample_t     history[WINDOW_DEPTH];
    int unsigned next_slot;
    int unsigned stream_fill;
    cfg_len_t    window_len;
    sample_t     expected_max_q[$];
    int unsigned mismatches;
    int unsigned maxima_checked;
    int unsigned samples_seen;

    function new();
      next_slot      = 0;
      stream_fill    = 0;
      window_len     = WINDOW_LENGTH_RST;
      mismatches     = 0;
      maxima_checked = 0;
      samples_seen   = 0;
    endfunction

    function void set_window_length(cfg_len_t value);
      window_len = value;
    endfunction

    // zero acts as one, anything past the store depth is clamped
    function int unsigned span();
      int unsigned n;
      n = window_len;
      if (n == 0) n = 1;
      if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
      return n;
    endfunction

    function void note_sample(sample_t value, bit first);
      int unsigned n;
      int unsigned pos;
      sample_t     best;
      samples_seen++;
      if (first) stream_fill = 0;
      history[next_slot] = value;
      next_slot = (next_slot + 1) % WINDOW_DEPTH;
      if (stream_fill < WINDOW_DEPTH) stream_fill++;
      n = span();
      if (stream_fill < n) return;
      best = value;
      pos  = next_slot;
      for (int k = 0; k < n; k++) begin
        pos = (pos == 0) ? WINDOW_DEPTH - 1 : pos - 1;
        if (history[pos] > best) best = history[pos];
      end
      expected_max_q = {expected_max_q, best};
    endfunction

    function void check_result(sample_t got);
      sample_t want;
      if (expected_max_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: unexpected window_maximum %0d, none pending", $realtime, got);
        return;
      end
      want = expected_max_q.pop_front();
      maxima_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: window_maximum mismatch: expected %0d (%h), got %0d (%h)",
                   $realtime, want, want, got, got);
      end
    endfunction

    function int pending();
      return expected_max_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;

  window_max_scoreboard sb = new();
  bit          calm = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned settings_used = 0;
  sample_t     last_sent = '0;

  sliding_window_max_filter_top #(.MAX_WINDOW(WINDOW_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] sample
    .in_tuser   (in_tuser),   // [0] stream_start
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] window_maximum
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // everything sampled here holds its pre-edge value
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) sb.set_window_length(cfg_len_t'(cfg_wr_data));
      if (in_tvalid && in_tready) sb.note_sample(sample_t'(in_tdata), in_tuser[0]);
      if (out_tvalid && out_tready) sb.check_result(sample_t'(out_tdata));
      if (cfg_wr_en || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_sample(input sample_t value, input bit first);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= first;
    last_sent = value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // block may still hold a result for the last sample, so let it drain
  // wait for the clock first so the scoreboard has seen the last request
  task automatic wait_idle(input int extra);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_window_length(input logic [6:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
  endtask

  function sample_t pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) begin
      case ($urandom_range(5))
        0: return SAMPLE_MIN;
        1: return SAMPLE_MAX;
        2: return sample_t'(0);
        3: return sample_t'(-1);
        4: return SAMPLE_MIN + 1;
        default: return SAMPLE_MAX - 1;
      endcase
    end
    // narrow range gives plenty of ties
    if (r < 35) return sample_t'($signed($urandom_range(16)) - 8);
    // a falling run makes the old maximum leave the window as it slides
    if (r < 60) return last_sent - sample_t'($urandom_range(40000));
    return sample_t'($urandom);
  endfunction

  task automatic run_stream_phase(input logic [6:0] len_value);
    int unsigned n;
    int unsigned count;
    n = (len_value == 0) ? 1 : ((len_value > WINDOW_DEPTH) ? WINDOW_DEPTH : len_value);
    count = (n <= 8) ? 50 : n + 40;
    wait_idle(DRAIN_CYCLES);
    write_window_length(len_value);
    // the first sample starts a new stream at random, so the new length may apply mid-stream
    send_sample(pick_sample(), $urandom_range(1));
    for (int i = 1; i < count; i++)
      send_sample(pick_sample(), $urandom_range(2 * n + 24) == 0);
  endtask

  initial begin
    logic [6:0] lens[12];
    lens = '{7'd64, 7'd5, 7'd127, 7'd1, 7'd17, 7'd0, 7'd65, 7'd2, 7'd0, 7'd0, 7'd3, 7'd64};
    lens[8] = 7'($urandom_range(1, WINDOW_DEPTH));
    lens[9] = 7'($urandom_range(1, WINDOW_DEPTH));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length of three
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(sample_t'(0), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(sample_t'(1), 1'b1);
    send_sample(sample_t'(7), 1'b0);

    // pass through
    wait_idle(DRAIN_CYCLES);
    write_window_length(7'd1);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(0), 1'b1);

    // zero length behaves as one
    wait_idle(DRAIN_CYCLES);
    write_window_length(7'd0);
    send_sample(sample_t'(-5), 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(sample_t'(-6), 1'b0);

    // longer length while the stream runs, then a restart inside the phase
    wait_idle(DRAIN_CYCLES);
    write_window_length(7'd4);
    send_sample(sample_t'(3), 1'b0);
    send_sample(sample_t'(-3), 1'b0);
    send_sample(sample_t'(2), 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN + 1, 1'b0);
    send_sample(sample_t'(-2), 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);

    foreach (lens[p]) begin
      calm = (p == 4);
      run_stream_phase(lens[p]);
    end
    calm = 1'b0;

    wait_idle(DRAIN_CYCLES * 2);

    $display("ran %0d samples over %0d window length settings (0, 1, 64, 65, 127 among them)",
             sb.samples_seen, settings_used);
    $display("checked %0d window maxima, %0d mismatches", sb.maxima_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

### sliding_window_max_filter_top.f
+incdir+rtl/core
rtl/core/swm_pkg.sv
rtl/core/swm_cell.sv
rtl/core/swm_chain.sv
rtl/core/sliding_window_max_filter_top.sv
dv/tb.sv
